[hw/rtl/gdb_pkg.sv]
// ---------------------------------------------------------------------------
// gdb_pkg: shared types and constants for gradient direction binning
// Register map, bin codes and the control bundle that walks the cell chain.
// ---------------------------------------------------------------------------
`default_nettype none

package gdb_pkg;

	// threshold registers
	localparam int unsigned THR_W    = 20;
	localparam int unsigned ADDR_W   = 5;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned REGIDX_W = 3;

	localparam logic [REGIDX_W-1:0] REG_THR_22_5       = 3'd0;
	localparam logic [REGIDX_W-1:0] REG_THR_22_5_PLUS  = 3'd1;
	localparam logic [REGIDX_W-1:0] REG_THR_22_5_MINUS = 3'd2;
	localparam logic [REGIDX_W-1:0] REG_THR_67_5       = 3'd3;
	localparam logic [REGIDX_W-1:0] REG_THR_67_5_PLUS  = 3'd4;
	localparam logic [REGIDX_W-1:0] REG_THR_67_5_MINUS = 3'd5;

	localparam logic [THR_W-1:0] THR_22_5_RST = 20'd424;
	localparam logic [THR_W-1:0] THR_67_5_RST = 20'd2472;

	// bin codes (4-bit two's complement, -1 means no bin)
	localparam int unsigned BIN_W = 4;
	localparam logic [BIN_W-1:0] BIN_NONE = 4'hF;

	typedef struct packed {
		logic [THR_W-1:0] a;   // tan 22.5
		logic [THR_W-1:0] ap;  // tan 22.5 + overlap
		logic [THR_W-1:0] am;  // tan 22.5 - overlap
		logic [THR_W-1:0] c;   // tan 67.5
		logic [THR_W-1:0] cp;  // tan 67.5 + overlap
		logic [THR_W-1:0] cm;  // tan 67.5 - overlap
	} thr_set_t;

	// per-pixel flags carried alongside the divider
	typedef struct packed {
		logic edge_px;
		logic du_zero;
		logic du_neg;
		logic dv_pos;
		logic dv_neg;
	} px_flags_t;

endpackage

`default_nettype wire

[hw/rtl/gdb_div_cell.sv]
// ---------------------------------------------------------------------------
// gdb_div_cell: one restoring-division step of the slope pipeline
// Brings in one numerator bit, subtracts the divisor if it fits, registers.
// ---------------------------------------------------------------------------
`default_nettype none

module gdb_div_cell #(
	parameter int GW = 16,
	parameter int NW = 26
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               vld_i,
	input  wire gdb_pkg::px_flags_t flags_i,
	input  wire logic [GW:0]        mag_i,
	input  wire logic [GW-1:0]      dvs_i,
	input  wire logic [GW-1:0]      rem_i,
	input  wire logic [NW-1:0]      nq_i,
	output logic                    vld_q,
	output gdb_pkg::px_flags_t      flags_q,
	output logic [GW:0]             mag_q,
	output logic [GW-1:0]           dvs_q,
	output logic [GW-1:0]           rem_q,
	output logic [NW-1:0]           nq_q
);

	logic [GW:0]   trial;
	logic [GW:0]   diff;
	logic          fits;
	logic [GW-1:0] rem_nxt;

	// remainder stays below the divisor, so GW bits hold it
	assign trial   = {rem_i, nq_i[NW-1]};
	assign diff    = trial - {1'b0, dvs_i};
	assign fits    = trial >= {1'b0, dvs_i};
	assign rem_nxt = fits ? diff[GW-1:0] : trial[GW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_q <= flags_i;
			mag_q   <= mag_i;
			dvs_q   <= dvs_i;
			rem_q   <= rem_nxt;
			nq_q    <= {nq_i[NW-2:0], fits};  // quotient bit shifts in at the bottom
		end
	end

endmodule

`default_nettype wire

[hw/rtl/gdb_bin_classify.sv]
// ---------------------------------------------------------------------------
// gdb_bin_classify: slope-to-bin decision and result register
// Compares |slope| with the six thresholds per quadrant and holds the beat.
// ---------------------------------------------------------------------------
`default_nettype none

module gdb_bin_classify #(
	parameter int GW = 16,
	parameter int NW = 26
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           vld_i,
	input  wire gdb_pkg::px_flags_t             flags_i,
	input  wire logic [GW:0]                    mag_i,
	input  wire logic [NW-1:0]                  quo_i,
	input  wire gdb_pkg::thr_set_t              thr,
	output logic                                vld_q,
	output logic [gdb_pkg::BIN_W-1:0]           pri_q,
	output logic [gdb_pkg::BIN_W-1:0]           sec_q,
	output logic [GW:0]                         mag_q
);

	localparam int CMPW = (NW > int'(gdb_pkg::THR_W)) ? NW : int'(gdb_pkg::THR_W);

	logic [CMPW-1:0] q;
	logic lt_a, gt_a, lt_c, gt_c;
	logic lt_ap, gt_am, lt_cp, gt_cm;
	logic [gdb_pkg::BIN_W-1:0] b1, b2;
	logic [gdb_pkg::BIN_W-1:0] lo, mid, hi;

	assign q     = CMPW'(quo_i);
	assign lt_a  = q <  CMPW'(thr.a);
	assign gt_a  = q >  CMPW'(thr.a);
	assign lt_c  = q <  CMPW'(thr.c);
	assign gt_c  = q >  CMPW'(thr.c);
	assign lt_ap = q <  CMPW'(thr.ap);
	assign gt_am = q >  CMPW'(thr.am);
	assign lt_cp = q <  CMPW'(thr.cp);
	assign gt_cm = q >  CMPW'(thr.cm);

	always_comb begin
		b1  = gdb_pkg::BIN_NONE;
		b2  = gdb_pkg::BIN_NONE;
		lo  = 4'd0;
		mid = 4'd1;
		hi  = 4'd2;
		if (!flags_i.edge_px) begin
			b1 = gdb_pkg::BIN_NONE;
		end else if (flags_i.du_zero) begin
			if (flags_i.dv_pos) begin
				b1 = 4'd2;
			end else if (flags_i.dv_neg) begin
				b1 = 4'd6;
			end
		end else if (flags_i.du_neg && flags_i.dv_pos) begin
			// slope negative: borders flip, ties fall differently
			if (gt_c) begin
				b1 = 4'd2;
				if (lt_cp) b2 = 4'd3;
			end else if (gt_a) begin
				b1 = 4'd3;
				if (gt_cm) b2 = 4'd2;
				else if (lt_ap) b2 = 4'd4;
			end else begin
				b1 = 4'd4;
				if (gt_am) b2 = 4'd3;
			end
		end else begin
			// first, fourth and third quadrants share one comparison shape
			if (!flags_i.du_neg && flags_i.dv_pos) begin
				lo = 4'd0; mid = 4'd1; hi = 4'd2;
			end else if (!flags_i.du_neg) begin
				lo = 4'd0; mid = 4'd7; hi = 4'd6;
			end else begin
				lo = 4'd4; mid = 4'd5; hi = 4'd6;
			end
			if (lt_a) begin
				b1 = lo;
				if (gt_am) b2 = mid;
			end else if (lt_c) begin
				b1 = mid;
				if (lt_ap) b2 = lo;
				else if (gt_cm) b2 = hi;
			end else begin
				b1 = hi;
				if (lt_cp) b2 = mid;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pri_q <= b1;
			sec_q <= b2;
			mag_q <= mag_i;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/gradient_direction_binning_unit.sv]
// ---------------------------------------------------------------------------
// gradient_direction_binning_unit: 8-bin gradient orientation quantizer
// Slope by a pipelined restoring divider, then threshold binning per pixel.
// ---------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   -----------------------------------------
//  in        in_valid / in_ready    is_edge, grad_u, grad_v
//  out       out_valid / out_ready  primary_bin, secondary_bin, grad_magnitude
//  cfg       APB, pready tied high  thr_22_5 .. thr_67_5_minus at 4*i
//
//  One beat per clock while the chain is not stalled. The stages are an
//  input stage, one divider cell per quotient bit and a bin stage.
//  The whole chain advances together; it stalls only while a result beat
//  sits in the output register and out_ready is low.
//  Reset clears the valid bits of every stage and loads threshold defaults.
//
`default_nettype none

module gradient_direction_binning_unit #(
	parameter int SLOPE_FRAC_BITS = 10,
	parameter int GRAD_WIDTH      = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// pixel input
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              is_edge,
	input  wire logic signed [GRAD_WIDTH-1:0]      grad_u,
	input  wire logic signed [GRAD_WIDTH-1:0]      grad_v,
	// result output
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [gdb_pkg::BIN_W-1:0]       primary_bin,
	output logic signed [gdb_pkg::BIN_W-1:0]       secondary_bin,
	output logic [GRAD_WIDTH:0]                    grad_magnitude,
	// register port
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [gdb_pkg::ADDR_W-1:0]        paddr,
	input  wire logic [gdb_pkg::DATA_W-1:0]        pwdata,
	output logic [gdb_pkg::DATA_W-1:0]             prdata,
	output logic                                   pready
);

	localparam int GW = GRAD_WIDTH;
	localparam int NW = GRAD_WIDTH + SLOPE_FRAC_BITS;  // quotient bits = cells

	// ---------------- threshold registers ----------------
	gdb_pkg::thr_set_t                thr_q;
	logic                             wr_en;
	logic [gdb_pkg::REGIDX_W-1:0]     reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[gdb_pkg::ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.a  <= gdb_pkg::THR_22_5_RST;
			thr_q.ap <= gdb_pkg::THR_22_5_RST;
			thr_q.am <= gdb_pkg::THR_22_5_RST;
			thr_q.c  <= gdb_pkg::THR_67_5_RST;
			thr_q.cp <= gdb_pkg::THR_67_5_RST;
			thr_q.cm <= gdb_pkg::THR_67_5_RST;
		end else if (wr_en) begin
			case (reg_idx)
				gdb_pkg::REG_THR_22_5:       thr_q.a  <= pwdata[gdb_pkg::THR_W-1:0];
				gdb_pkg::REG_THR_22_5_PLUS:  thr_q.ap <= pwdata[gdb_pkg::THR_W-1:0];
				gdb_pkg::REG_THR_22_5_MINUS: thr_q.am <= pwdata[gdb_pkg::THR_W-1:0];
				gdb_pkg::REG_THR_67_5:       thr_q.c  <= pwdata[gdb_pkg::THR_W-1:0];
				gdb_pkg::REG_THR_67_5_PLUS:  thr_q.cp <= pwdata[gdb_pkg::THR_W-1:0];
				gdb_pkg::REG_THR_67_5_MINUS: thr_q.cm <= pwdata[gdb_pkg::THR_W-1:0];
				default: ;  // unmapped: dropped
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			gdb_pkg::REG_THR_22_5:       prdata = gdb_pkg::DATA_W'(thr_q.a);
			gdb_pkg::REG_THR_22_5_PLUS:  prdata = gdb_pkg::DATA_W'(thr_q.ap);
			gdb_pkg::REG_THR_22_5_MINUS: prdata = gdb_pkg::DATA_W'(thr_q.am);
			gdb_pkg::REG_THR_67_5:       prdata = gdb_pkg::DATA_W'(thr_q.c);
			gdb_pkg::REG_THR_67_5_PLUS:  prdata = gdb_pkg::DATA_W'(thr_q.cp);
			gdb_pkg::REG_THR_67_5_MINUS: prdata = gdb_pkg::DATA_W'(thr_q.cm);
			default:                     prdata = '0;
		endcase
	end

	// ---------------- chain enable ----------------
	// every stage moves together; the output register is the only holder
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// ---------------- input stage: signs, magnitudes, |du|+|dv| ----------------
	logic               du_neg, dv_neg;
	logic [GW-1:0]      abs_u, abs_v;
	gdb_pkg::px_flags_t flg_in;

	assign du_neg = grad_u[GW-1];
	assign dv_neg = grad_v[GW-1];
	assign abs_u  = du_neg ? (~grad_u + 1'b1) : grad_u;  // most negative value maps to 2^(GW-1)
	assign abs_v  = dv_neg ? (~grad_v + 1'b1) : grad_v;

	always_comb begin
		flg_in.edge_px = is_edge;
		flg_in.du_zero = (grad_u == '0);
		flg_in.du_neg  = du_neg;
		flg_in.dv_neg  = dv_neg;
		flg_in.dv_pos  = !dv_neg && (grad_v != '0);
	end

	logic               vld_s1;
	gdb_pkg::px_flags_t flg_s1;
	logic [GW:0]        mag_s1;
	logic [GW-1:0]      dvs_s1;
	logic [NW-1:0]      num_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flg_s1 <= flg_in;
			mag_s1 <= is_edge ? ({1'b0, abs_u} + {1'b0, abs_v}) : '0;
			dvs_s1 <= abs_u;
			num_s1 <= {abs_v, {SLOPE_FRAC_BITS{1'b0}}};  // |dv| scaled by 2^frac
		end
	end

	// ---------------- divider cell chain ----------------
	// tap k feeds cell k; tap NW holds the finished |slope|
	logic               vld_c [NW+1];
	gdb_pkg::px_flags_t flg_c [NW+1];
	logic [GW:0]        mag_c [NW+1];
	logic [GW-1:0]      dvs_c [NW+1];
	logic [GW-1:0]      rem_c [NW+1];
	logic [NW-1:0]      nq_c  [NW+1];

	assign vld_c[0] = vld_s1;
	assign flg_c[0] = flg_s1;
	assign mag_c[0] = mag_s1;
	assign dvs_c[0] = dvs_s1;
	assign rem_c[0] = '0;
	assign nq_c[0]  = num_s1;

	for (genvar k = 0; k < NW; k++) begin : g_cell
		gdb_div_cell #(
			.GW (GW),
			.NW (NW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_i   (vld_c[k]),
			.flags_i (flg_c[k]),
			.mag_i   (mag_c[k]),
			.dvs_i   (dvs_c[k]),
			.rem_i   (rem_c[k]),
			.nq_i    (nq_c[k]),
			.vld_q   (vld_c[k+1]),
			.flags_q (flg_c[k+1]),
			.mag_q   (mag_c[k+1]),
			.dvs_q   (dvs_c[k+1]),
			.rem_q   (rem_c[k+1]),
			.nq_q    (nq_c[k+1])
		);
	end

	// ---------------- bin decision and output register ----------------
	// divisor and remainder of the last tap are not needed past the chain;
	// a zero |du| gives a meaningless quotient that the du_zero flag masks.
	logic [gdb_pkg::BIN_W-1:0] pri_w, sec_w;

	gdb_bin_classify #(
		.GW (GW),
		.NW (NW)
	) u_classify (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (vld_c[NW]),
		.flags_i (flg_c[NW]),
		.mag_i   (mag_c[NW]),
		.quo_i   (nq_c[NW]),
		.thr     (thr_q),
		.vld_q   (out_valid),
		.pri_q   (pri_w),
		.sec_q   (sec_w),
		.mag_q   (grad_magnitude)
	);

	assign primary_bin   = pri_w;
	assign secondary_bin = sec_w;

	// ---------------- checks ----------------
	logic [2:0] bin_step;
	assign bin_step = sec_w[2:0] - pri_w[2:0];

	// no secondary without a primary
	a_sec_needs_pri: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pri_w == gdb_pkg::BIN_NONE) |-> (sec_w == gdb_pkg::BIN_NONE))
		else $error("secondary bin without primary bin");

	// a pixel gets a bin exactly when its gradient sum is nonzero
	a_bin_vs_mag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((pri_w == gdb_pkg::BIN_NONE) == (grad_magnitude == '0)))
		else $error("primary bin disagrees with gradient magnitude");

	// secondary is always a neighbor of the primary
	a_sec_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (sec_w != gdb_pkg::BIN_NONE) |->
			(!sec_w[3] && !pri_w[3] && ((bin_step == 3'd1) || (bin_step == 3'd7))))
		else $error("secondary bin not adjacent to primary");

	// a stall freezes the divider chain
	a_chain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(vld_c[NW]) && $stable(nq_c[NW]) && $stable(vld_s1)))
		else $error("divider chain moved during a stall");

endmodule

`default_nettype wire
